// File: rtl/core/mono_note_priority_voice_defines.svh
// Assertion macros for the monophonic key handler.
// Used by the top level; needs clk and arst_n in scope.
`ifndef MONO_NOTE_PRIORITY_VOICE_DEFINES_SVH
`define MONO_NOTE_PRIORITY_VOICE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define NMPV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nmpv check failed");

// Next-cycle implication, checked outside reset
`define NMPV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nmpv check failed");

`endif

// File: rtl/core/nmpv_pkg.sv
// Shared types and constants for the monophonic key handler.
// No dependencies; imported by every module of the block.
package nmpv_pkg;

	localparam int KEY_SLOTS = 16;
	localparam int CNT_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int NOTE_W    = 7;
	localparam int VEL_W     = 7;

	localparam logic [NOTE_W-1:0] NOTE_MIN = 7'd21;
	localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd96;
	localparam logic [NOTE_W:0]   LOW_NONE = 8'hFF;

	// Note priority codes; code 3 behaves as last note
	localparam logic [1:0] PRIO_LAST = 2'd0;
	localparam logic [1:0] PRIO_HIGH = 2'd1;
	localparam logic [1:0] PRIO_LOW  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_PRIORITY = 2'd0;
	localparam logic [1:0] CFG_LEGATO   = 2'd1;
	localparam logic [1:0] CFG_SYNC     = 2'd2;

	typedef struct packed {
		logic              busy;
		logic [NOTE_W-1:0] note;
	} slot_t;

	typedef struct packed {
		logic [1:0] prio;
		logic       legato;
		logic       sync;
	} cfg_t;

	typedef struct packed {
		logic              gate_write;
		logic              gate_level;
		logic              trigger_fire;
		logic [VEL_W-1:0]  trigger_velocity;
		logic              lfo_restart;
		logic              pitch_write;
		logic [NOTE_W-1:0] pitch_note;
	} result_t;

	typedef struct packed {
		logic idle;
		logic shift;
		logic emit;
	} scan_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

// File: rtl/core/nmpv_cell.sv
// One key slot of the rotating slot ring.
// Depends on nmpv_pkg for the slot type.
module nmpv_cell import nmpv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  slot_t nxt,
	output slot_t cur
);

	logic              busy_q;
	logic [NOTE_W-1:0] note_q;

	// Take the neighbor's busy flag on each shift; reset frees the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (shift) begin
			busy_q <= nxt.busy;
		end
	end

	// Take the neighbor's note on each shift
	always_ff @(posedge clk) begin
		if (shift) begin
			note_q <= nxt.note;
		end
	end

	assign cur = '{busy: busy_q, note: note_q};

endmodule

// File: rtl/core/nmpv_scan.sv
// Sequencer at the head of the slot ring: insert, free, min/max scan, result.
// Depends on nmpv_pkg for types, codes and the slot count.
module nmpv_scan import nmpv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op,
	input  logic [NOTE_W-1:0] note,
	input  logic [VEL_W-1:0]  vel,
	input  cfg_t              cfg,
	input  logic              out_free,
	input  slot_t             head,
	output slot_t             wb,
	output scan_ctl_t         ctl,
	output result_t           res
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              op_q;
	logic              inr_q;
	logic [NOTE_W-1:0] note_q;
	logic [VEL_W-1:0]  vel_q;
	logic              done_q;
	logic              any_q;
	logic [NOTE_W:0]   min_q;
	logic [NOTE_W-1:0] max_q;
	logic              hit_ins;
	logic              hit_del;
	slot_t             src;
	logic              last;
	logic              loses;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign last = (cnt_q == CNT_W'(KEY_SLOTS - 1));

	// Next state and control
	always_comb begin
		state_d   = state_q;
		ctl.idle  = 1'b0;
		ctl.shift = 1'b0;
		ctl.emit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.idle = 1'b1;
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.shift = 1'b1;
				if (last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					ctl.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Slot counter over one full turn of the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (ctl.shift) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Hold the event for the whole scan
	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= op;
			note_q <= note;
			vel_q  <= vel;
			inr_q  <= (note >= NOTE_MIN) && (note <= NOTE_MAX);
		end
	end

	// Modify the head slot: fill the first free one or free the first match
	always_comb begin
		hit_ins = inr_q && op_q && !done_q && !head.busy;
		hit_del = inr_q && !op_q && !done_q && head.busy && (head.note == note_q);
		priority if (hit_ins) begin
			wb = '{busy: 1'b1, note: note_q};
		end else if (hit_del) begin
			wb = '{busy: 1'b0, note: head.note};
		end else begin
			wb = head;
		end
		// Note-on looks at the table before the insert, note-off after the free
		src = op_q ? head : wb;
	end

	// Accumulate held-key flag, lowest and highest note
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			any_q  <= 1'b0;
			min_q  <= LOW_NONE;
			max_q  <= '0;
		end else if (start) begin
			done_q <= 1'b0;
			any_q  <= 1'b0;
			min_q  <= LOW_NONE;
			max_q  <= '0;
		end else if (ctl.shift) begin
			done_q <= done_q | hit_ins | hit_del;
			any_q  <= any_q | src.busy;
			if (src.busy && ({1'b0, src.note} < min_q)) begin
				min_q <= {1'b0, src.note};
			end
			if (src.busy && (src.note > max_q)) begin
				max_q <= src.note;
			end
		end
	end

	// Build the result from the scan totals
	always_comb begin
		loses = ((cfg.prio == PRIO_LOW) && ({1'b0, note_q} > min_q)) ||
		        ((cfg.prio == PRIO_HIGH) && (note_q < max_q));
		res = '0;
		if (inr_q) begin
			if (op_q) begin
				if (loses) begin
					if (!cfg.legato) begin
						res.trigger_fire     = 1'b1;
						res.trigger_velocity = vel_q;
					end
				end else begin
					res.gate_write = 1'b1;
					res.gate_level = 1'b1;
					if (!cfg.legato || !any_q) begin
						res.trigger_fire     = 1'b1;
						res.trigger_velocity = vel_q;
					end
					res.lfo_restart = cfg.sync;
					res.pitch_write = 1'b1;
					res.pitch_note  = note_q;
				end
			end else if (done_q) begin
				priority if (!any_q) begin
					res.gate_write = 1'b1;
					res.gate_level = 1'b0;
				end else if (cfg.prio == PRIO_LOW) begin
					res.pitch_write = 1'b1;
					res.pitch_note  = min_q[NOTE_W-1:0];
				end else if (cfg.prio == PRIO_HIGH) begin
					res.pitch_write = 1'b1;
					res.pitch_note  = max_q;
				end else begin
					res.pitch_write = 1'b0;
				end
			end
		end
	end

endmodule

// File: rtl/core/mono_note_priority_voice.sv
// Monophonic key handler: note events in, voice control results out.
// A ring of key slot cells rotates once per event under a head sequencer.
// Channels: evt (operation, note, velocity) with evt_valid/evt_stall; res
// (gate, trigger, LFO and pitch updates) with res_valid/res_stall; cfg
// register writes with cfg_valid/cfg_ready, cfg_index and cfg_data.
// Each event produces exactly one result transaction.
// The result is loaded into the output register after one turn of the slot
// ring, as soon as that register is free.
// A new event is taken only after the result of the last one is loaded;
// the slot ring turns once per event, one slot through the head each cycle.
// evt_stall is high from acceptance until the result is loaded.
// A stalled result holds in the output register while the next event is
// taken and scanned; that event then waits until the register frees.
// Reset frees every slot, clears the output valid flag and loads the
// registers with last-note priority, legato off and LFO sync on.
// cfg_ready is always high; write registers only while the block is idle.
`include "mono_note_priority_voice_defines.svh"
module mono_note_priority_voice import nmpv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	output logic              evt_stall,
	input  logic              operation,
	input  logic [NOTE_W-1:0] note,
	input  logic [VEL_W-1:0]  velocity,
	output logic              res_valid,
	input  logic              res_stall,
	output logic              gate_write,
	output logic              gate_level,
	output logic              trigger_fire,
	output logic [VEL_W-1:0]  trigger_velocity,
	output logic              lfo_restart,
	output logic              pitch_write,
	output logic [NOTE_W-1:0] pitch_note,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [1:0]        cfg_data
);

	cfg_t      cfg_q;
	scan_ctl_t ctl;
	result_t   res_d;
	result_t   res_q;
	logic      res_valid_q;
	logic      start;
	logic      out_free;
	slot_t     wb;
	slot_t     slot [KEY_SLOTS];

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prio   <= PRIO_LAST;
			cfg_q.legato <= 1'b0;
			cfg_q.sync   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PRIORITY: cfg_q.prio   <= cfg_data;
				CFG_LEGATO:   cfg_q.legato <= cfg_data[0];
				CFG_SYNC:     cfg_q.sync   <= cfg_data[0];
				default:      cfg_q        <= cfg_q;
			endcase
		end
	end

	assign evt_stall = !ctl.idle;
	assign start     = evt_valid && !evt_stall;
	assign out_free  = !res_valid_q || !res_stall;

	// Head sequencer
	nmpv_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op       (operation),
		.note     (note),
		.vel      (velocity),
		.cfg      (cfg_q),
		.out_free (out_free),
		.head     (slot[0]),
		.wb       (wb),
		.ctl      (ctl),
		.res      (res_d)
	);

	// Slot ring: each cell takes its upper neighbor, the last takes the head
	for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_cell
		if (i == KEY_SLOTS - 1) begin : g_tail
			nmpv_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ctl.shift),
				.nxt    (wb),
				.cur    (slot[i])
			);
		end else begin : g_body
			nmpv_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ctl.shift),
				.nxt    (slot[i+1]),
				.cur    (slot[i])
			);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid        = res_valid_q;
	assign gate_write       = res_q.gate_write;
	assign gate_level       = res_q.gate_level;
	assign trigger_fire     = res_q.trigger_fire;
	assign trigger_velocity = res_q.trigger_velocity;
	assign lfo_restart      = res_q.lfo_restart;
	assign pitch_write      = res_q.pitch_write;
	assign pitch_note       = res_q.pitch_note;

	// Checks on the sequencer and the result encoding
	`NMPV_ASSERT_NEXT(a_busy_after_accept, start, evt_stall)
	`NMPV_ASSERT_NOW(a_emit_needs_room, ctl.emit, out_free && !ctl.idle)
	`NMPV_ASSERT_NOW(a_lfo_with_gate, res_valid && lfo_restart, gate_write && gate_level)
	`NMPV_ASSERT_NOW(a_pitch_zero, res_valid && !pitch_write, pitch_note == '0)

endmodule
